// File: rtl/stereo_peak_meter_ballistics_top_defines.svh
// ----------------------------------------------------------------------------
// Stereo peak meter assertion macros
// Shared concurrent assertion forms for the meter's checkers.
// ----------------------------------------------------------------------------
`ifndef STEREO_PEAK_METER_BALLISTICS_TOP_DEFINES_SVH
`define STEREO_PEAK_METER_BALLISTICS_TOP_DEFINES_SVH

// same-cycle implication, masked during reset
`define SPMB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("spmb check failed");

// next-cycle implication, masked during reset
`define SPMB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("spmb check failed");

// next-cycle implication, live through reset
`define SPMB_ASSERT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("spmb check failed");

`endif

// File: rtl/spmb_pkg.sv
// ----------------------------------------------------------------------------
// Stereo peak meter package
// Widths, register indexes, reset values and shared types.
// ----------------------------------------------------------------------------
package spmb_pkg;

   localparam int SAMPLE_BITS   = 24;
   localparam int FACTOR_BITS   = 16;
   localparam int HOLD_BITS     = 16;
   localparam int CSR_IDX_BITS  = 8;
   localparam int CSR_DATA_BITS = 24;
   localparam int REQ_DATA_BITS = 2 * SAMPLE_BITS;
   localparam int RSP_RAW_BITS  = 4 * SAMPLE_BITS + 2;
   localparam int RSP_DATA_BITS = ((RSP_RAW_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_BITS  = RSP_DATA_BITS - RSP_RAW_BITS;
   localparam int FIFO_DEPTH    = 4;
   localparam int FIFO_PTR_BITS = 2;
   localparam int FIFO_CNT_BITS = 3;

   localparam logic [CSR_IDX_BITS-1:0] CSR_LEVEL_DECAY = 8'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HOLD_BLOCKS = 8'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PEAK_DECAY  = 8'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CLIP_THRESH = 8'd3;

   localparam logic [FACTOR_BITS-1:0] LEVEL_DECAY_RST = 16'd55640;
   localparam logic [HOLD_BITS-1:0]   HOLD_BLOCKS_RST = 16'd140;
   localparam logic [FACTOR_BITS-1:0] PEAK_DECAY_RST  = 16'd65208;
   localparam logic [SAMPLE_BITS-1:0] CLIP_THRESH_RST = 24'd8304722;

   typedef struct packed {
      logic [FACTOR_BITS-1:0] level_decay;
      logic [HOLD_BITS-1:0]   hold_blocks;
      logic [FACTOR_BITS-1:0] peak_decay;
      logic [SAMPLE_BITS-1:0] clip_thresh;
   } cfg_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] level;
      logic [SAMPLE_BITS-1:0] peak;
      logic                   clip;
   } lane_res_type;

endpackage

// File: rtl/spmb_lane.sv
// ----------------------------------------------------------------------------
// Stereo peak meter channel lane
// Magnitude, running block max, then level / held peak / clip update.
// ----------------------------------------------------------------------------
module spmb_lane (
   input  logic                            clock,
   input  logic                            reset,
   input  spmb_pkg::cfg_type               cfg,
   input  logic                            in_beat,
   input  logic                            in_last,
   input  logic [spmb_pkg::SAMPLE_BITS-1:0] in_sample,
   input  logic                            upd,
   output spmb_pkg::lane_res_type          res
);
   import spmb_pkg::*;

   localparam int PROD_BITS = SAMPLE_BITS + FACTOR_BITS;

   logic [SAMPLE_BITS-1:0] mag;
   logic [SAMPLE_BITS-1:0] run_max;
   logic [SAMPLE_BITS-1:0] run_ff, run_in;
   logic [SAMPLE_BITS-1:0] blk_ff, blk_in;
   logic [SAMPLE_BITS-1:0] level_ff, level_in;
   logic [SAMPLE_BITS-1:0] peak_ff, peak_in;
   logic [HOLD_BITS-1:0]   hold_ff, hold_in;
   logic                   clip_ff, clip_in;
   logic [PROD_BITS-1:0]   level_prod;
   logic [PROD_BITS-1:0]   peak_prod;

   // stage 1: magnitude and running max
   always_comb begin
      mag     = in_sample[SAMPLE_BITS-1] ? (~in_sample + 1'b1) : in_sample;
      run_max = (mag > run_ff) ? mag : run_ff;
      run_in  = run_ff;
      blk_in  = blk_ff;
      if (in_beat) begin
         if (in_last) begin
            blk_in = run_max;
            run_in = '0;
         end else begin
            run_in = run_max;
         end
      end
   end

   // stage 2: ballistics
   always_comb begin
      level_prod = PROD_BITS'(level_ff) * PROD_BITS'(cfg.level_decay);
      peak_prod  = PROD_BITS'(peak_ff) * PROD_BITS'(cfg.peak_decay);
      level_in   = level_ff;
      peak_in    = peak_ff;
      hold_in    = hold_ff;
      clip_in    = clip_ff;
      if (upd) begin
         if (blk_ff > level_ff) begin
            level_in = blk_ff;
         end else begin
            level_in = level_prod[PROD_BITS-1:FACTOR_BITS];
         end
         if (blk_ff >= peak_ff) begin
            peak_in = blk_ff;
            hold_in = cfg.hold_blocks;
         end else if (hold_ff != '0) begin
            hold_in = hold_ff - 1'b1;
         end else begin
            peak_in = peak_prod[PROD_BITS-1:FACTOR_BITS];
         end
         if (blk_ff >= cfg.clip_thresh) begin
            clip_in = 1'b1;
         end
      end
      res.level = level_in;
      res.peak  = peak_in;
      res.clip  = clip_in;
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
      if (reset) begin
         run_ff   <= '0;
         level_ff <= '0;
         peak_ff  <= '0;
         hold_ff  <= '0;
         clip_ff  <= 1'b0;
      end else begin
         run_ff   <= run_in;
         level_ff <= level_in;
         peak_ff  <= peak_in;
         hold_ff  <= hold_in;
         clip_ff  <= clip_in;
      end
   end

endmodule

// File: rtl/spmb_merge.sv
// ----------------------------------------------------------------------------
// Stereo peak meter merge stage
// Packs both lane results into one beat and queues it for the output.
// ----------------------------------------------------------------------------
module spmb_merge (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   input  spmb_pkg::lane_res_type            left_res,
   input  spmb_pkg::lane_res_type            right_res,
   output logic                              in_ready,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [spmb_pkg::RSP_DATA_BITS-1:0] out_data
);
   import spmb_pkg::*;

   logic [RSP_DATA_BITS-1:0] mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0] wr_ff, wr_in;
   logic [FIFO_PTR_BITS-1:0] rd_ff, rd_in;
   logic [FIFO_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [RSP_DATA_BITS-1:0] packed_res;
   logic                     pop;

   always_comb begin
      packed_res = {{RSP_PAD_BITS{1'b0}}, right_res.clip, left_res.clip,
                    right_res.peak, left_res.peak, right_res.level, left_res.level};
      out_valid = (cnt_ff != '0);
      pop       = out_valid && out_ready;
      wr_in     = push ? wr_ff + 1'b1 : wr_ff;
      rd_in     = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in    = cnt_ff + FIFO_CNT_BITS'(push) - FIFO_CNT_BITS'(pop);
      out_data  = mem_ff[rd_ff];
      // room for the beat in flight plus one more
      in_ready  = ((cnt_ff + FIFO_CNT_BITS'(push)) <= FIFO_CNT_BITS'(FIFO_DEPTH - 2));
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= packed_res;
      end
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// File: rtl/stereo_peak_meter_ballistics_top.sv
// ----------------------------------------------------------------------------
// Stereo peak meter with ballistics, peak hold and clip latch
// A block-end beat is registered as block max and update flag, then queued.
// Throughput: 1 sample beat per cycle while req_tready is high; a block may be a single beat.
// The 4-entry result queue sets how long rsp_tready may stall before req stalls.
// Reset (synchronous): clears meter state and queue, loads register defaults.
// ----------------------------------------------------------------------------
module stereo_peak_meter_ballistics_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // left_sample[23:0], right_sample[47:24]
   input  logic [spmb_pkg::REQ_DATA_BITS-1:0] req_tdata,
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // left_level, right_level, left_held_peak, right_held_peak (24 each),
   // left_clip[96], right_clip[97], zero pad
   output logic [spmb_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [spmb_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [spmb_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import spmb_pkg::*;

   cfg_type      cfg_ff, cfg_in;
   logic         upd_ff, upd_in;
   logic         req_beat;
   lane_res_type left_res;
   lane_res_type right_res;

   assign csr_ready = 1'b1;
   assign req_beat  = req_tvalid && req_tready;
   assign upd_in    = req_beat && req_tlast;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_LEVEL_DECAY: cfg_in.level_decay = csr_wdata[FACTOR_BITS-1:0];
            CSR_HOLD_BLOCKS: cfg_in.hold_blocks = csr_wdata[HOLD_BITS-1:0];
            CSR_PEAK_DECAY:  cfg_in.peak_decay  = csr_wdata[FACTOR_BITS-1:0];
            CSR_CLIP_THRESH: cfg_in.clip_thresh = csr_wdata[SAMPLE_BITS-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.level_decay <= LEVEL_DECAY_RST;
         cfg_ff.hold_blocks <= HOLD_BLOCKS_RST;
         cfg_ff.peak_decay  <= PEAK_DECAY_RST;
         cfg_ff.clip_thresh <= CLIP_THRESH_RST;
         upd_ff             <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         upd_ff <= upd_in;
      end
   end

   spmb_lane u_left (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_beat   (req_beat),
      .in_last   (req_tlast),
      .in_sample (req_tdata[SAMPLE_BITS-1:0]),
      .upd       (upd_ff),
      .res       (left_res)
   );

   spmb_lane u_right (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_beat   (req_beat),
      .in_last   (req_tlast),
      .in_sample (req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
      .upd       (upd_ff),
      .res       (right_res)
   );

   spmb_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .push      (upd_ff),
      .left_res  (left_res),
      .right_res (right_res),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata)
   );

endmodule

// File: rtl/spmb_checker.sv
// ----------------------------------------------------------------------------
// Stereo peak meter port checker
// Watches the top level ports for output hold, clip latch and reset-empty behavior.
// ----------------------------------------------------------------------------
`include "stereo_peak_meter_ballistics_top_defines.svh"

module spmb_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [spmb_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);
   import spmb_pkg::*;

   localparam int LCLIP = 4 * SAMPLE_BITS;
   localparam int RCLIP = 4 * SAMPLE_BITS + 1;

   logic lclip_ff, lclip_in;
   logic rclip_ff, rclip_in;

   assign lclip_in = lclip_ff || (rsp_tvalid && rsp_tready && rsp_tdata[LCLIP]);
   assign rclip_in = rclip_ff || (rsp_tvalid && rsp_tready && rsp_tdata[RCLIP]);

   always_ff @(posedge clock) begin
      if (reset) begin
         lclip_ff <= 1'b0;
         rclip_ff <= 1'b0;
      end else begin
         lclip_ff <= lclip_in;
         rclip_ff <= rclip_in;
      end
   end

   `SPMB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata))
   `SPMB_ASSERT_NOW(a_lclip_sticky, clock, reset, rsp_tvalid && lclip_ff, rsp_tdata[LCLIP])
   `SPMB_ASSERT_NOW(a_rclip_sticky, clock, reset, rsp_tvalid && rclip_ff, rsp_tdata[RCLIP])
   `SPMB_ASSERT_ALWAYS(a_reset_empty, clock, reset, !rsp_tvalid)

endmodule

bind stereo_peak_meter_ballistics_top spmb_checker u_spmb_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// File: tb/stereo_peak_meter_ballistics_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo peak meter ballistics testbench
// Streams stereo sample beats into the meter. A cycle-free model tracks the
// running maxima, levels, held peaks, hold counters and clip latches, and
// predicts each block-end result. Directed beats cover sample extremes,
// register writes and the edge cases. Random blocks then run under three
// backpressure mixes with register changes between phases.
// ----------------------------------------------------------------------------
module stereo_peak_meter_ballistics_top_tb;
   import spmb_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int MAX_REPORTS    = 10;
   localparam logic [SAMPLE_BITS-1:0] NEG_FULL_SCALE = 24'h800000;
   localparam logic [SAMPLE_BITS-1:0] POS_FULL_SCALE = 24'h7FFFFF;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] left_level;
      logic [SAMPLE_BITS-1:0] right_level;
      logic [SAMPLE_BITS-1:0] left_peak;
      logic [SAMPLE_BITS-1:0] right_peak;
      logic                   left_clip;
      logic                   right_clip;
   } meter_res_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] run_max;
      logic [SAMPLE_BITS-1:0] level;
      logic [SAMPLE_BITS-1:0] peak;
      logic [HOLD_BITS-1:0]   hold;
      logic                   clip;
   } chan_state_type;

   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic                     req_tvalid  = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata   = '0;
   logic                     req_tlast   = 1'b0;
   logic                     rsp_tvalid;
   logic                     rsp_tready  = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     csr_valid   = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_BITS-1:0]  csr_index   = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata   = '0;

   int             send_idle_pct   = 0;
   int             ready_stall_pct = 0;
   int             mismatches      = 0;
   cfg_type        meter_cfg;
   chan_state_type left_chan;
   chan_state_type right_chan;
   meter_res_type  meter_q[$];

   stereo_peak_meter_ballistics_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= ready_stall_pct);
   end

   // ---------------- meter model ----------------
   function automatic logic [SAMPLE_BITS-1:0] magnitude_of(logic [SAMPLE_BITS-1:0] s);
      return s[SAMPLE_BITS-1] ? (~s + 1'b1) : s;
   endfunction

   function automatic void close_block(inout chan_state_type c);
      logic [SAMPLE_BITS+FACTOR_BITS-1:0] prod;
      if (c.run_max > c.level) begin
         c.level = c.run_max;
      end else begin
         prod = c.level * meter_cfg.level_decay;
         c.level = prod[SAMPLE_BITS+FACTOR_BITS-1:FACTOR_BITS];
      end
      if (c.run_max >= c.peak) begin
         c.peak = c.run_max;
         c.hold = meter_cfg.hold_blocks;
      end else if (c.hold != '0) begin
         c.hold = c.hold - 1'b1;
      end else begin
         prod = c.peak * meter_cfg.peak_decay;
         c.peak = prod[SAMPLE_BITS+FACTOR_BITS-1:FACTOR_BITS];
      end
      if (c.run_max >= meter_cfg.clip_thresh) c.clip = 1'b1;
      c.run_max = '0;
   endfunction

   function automatic void meter_accept(logic [SAMPLE_BITS-1:0] l, logic [SAMPLE_BITS-1:0] r,
                                        logic last);
      meter_res_type res;
      if (magnitude_of(l) > left_chan.run_max) left_chan.run_max = magnitude_of(l);
      if (magnitude_of(r) > right_chan.run_max) right_chan.run_max = magnitude_of(r);
      if (last) begin
         close_block(left_chan);
         close_block(right_chan);
         res.left_level  = left_chan.level;
         res.right_level = right_chan.level;
         res.left_peak   = left_chan.peak;
         res.right_peak  = right_chan.peak;
         res.left_clip   = left_chan.clip;
         res.right_clip  = right_chan.clip;
         meter_q.push_back(res);
      end
   endfunction

   // ---------------- result checker ----------------
   always @(posedge clock) begin
      meter_res_type got;
      meter_res_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.left_level  = rsp_tdata[SAMPLE_BITS-1:0];
         got.right_level = rsp_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
         got.left_peak   = rsp_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
         got.right_peak  = rsp_tdata[4*SAMPLE_BITS-1:3*SAMPLE_BITS];
         got.left_clip   = rsp_tdata[4*SAMPLE_BITS];
         got.right_clip  = rsp_tdata[4*SAMPLE_BITS+1];
         if (meter_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected result beat: %h", rsp_tdata);
         end else begin
            want = meter_q.pop_front();
            if (got.left_level !== want.left_level || got.right_level !== want.right_level ||
                got.left_peak !== want.left_peak || got.right_peak !== want.right_peak ||
                got.left_clip !== want.left_clip || got.right_clip !== want.right_clip) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("result mismatch: level L/R exp %h/%h got %h/%h",
                           want.left_level, want.right_level, got.left_level, got.right_level);
                  $display("  peak L/R exp %h/%h got %h/%h, clip L/R exp %b%b got %b%b",
                           want.left_peak, want.right_peak, got.left_peak, got.right_peak,
                           want.left_clip, want.right_clip, got.left_clip, got.right_clip);
               end
            end
         end
      end
   end

   // ---------------- watchdog ----------------
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Verification failed");
      $finish;
   end

   // ---------------- drivers ----------------
   task automatic send_sample(input logic [SAMPLE_BITS-1:0] l, input logic [SAMPLE_BITS-1:0] r,
                              input logic last);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {r, l};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      meter_accept(l, r, last);
   endtask

   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_LEVEL_DECAY: meter_cfg.level_decay = val[FACTOR_BITS-1:0];
         CSR_HOLD_BLOCKS: meter_cfg.hold_blocks = val[HOLD_BITS-1:0];
         CSR_PEAK_DECAY:  meter_cfg.peak_decay  = val[FACTOR_BITS-1:0];
         CSR_CLIP_THRESH: meter_cfg.clip_thresh = val[SAMPLE_BITS-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // sender holds off until every block result is back and the pipe is empty
   task automatic drain_meter();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (meter_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [CSR_IDX_BITS-1:0] unused_index();
      return CSR_IDX_BITS'(CSR_CLIP_THRESH + 1 + $urandom_range(0, 251));
   endfunction

   function automatic logic [CSR_DATA_BITS-1:0] pick_factor();
      case ($urandom_range(3))
         0: return '0;
         1: return {8'($urandom()), 16'hFFFF};
         default: return CSR_DATA_BITS'($urandom());
      endcase
   endfunction

   task automatic randomize_registers();
      logic [CSR_DATA_BITS-1:0] hold_val;
      logic [CSR_DATA_BITS-1:0] thresh_val;
      case ($urandom_range(5))
         0: hold_val = '0;
         1: hold_val = 24'h00FFFF;
         default: hold_val = CSR_DATA_BITS'($urandom_range(0, 6));
      endcase
      case ($urandom_range(5))
         0: thresh_val = '0;
         1: thresh_val = NEG_FULL_SCALE;
         default: thresh_val = CSR_DATA_BITS'($urandom_range(0, 8388608));
      endcase
      write_reg(CSR_LEVEL_DECAY, pick_factor());
      write_reg(CSR_HOLD_BLOCKS, hold_val);
      write_reg(CSR_PEAK_DECAY, pick_factor());
      write_reg(CSR_CLIP_THRESH, thresh_val);
      if ($urandom_range(1)) write_reg(unused_index(), CSR_DATA_BITS'($urandom()));
   endtask

   // favors the level and peak boundaries so equal-magnitude compares happen
   function automatic logic [SAMPLE_BITS-1:0] pick_sample(chan_state_type c);
      logic [SAMPLE_BITS-1:0] m;
      case ($urandom_range(11))
         0: return NEG_FULL_SCALE;
         1: return POS_FULL_SCALE;
         2: return '0;
         3: m = c.peak;
         4: m = c.level;
         5, 6: m = SAMPLE_BITS'($urandom_range(0, 4095));
         default: return SAMPLE_BITS'($urandom());
      endcase
      if (m == NEG_FULL_SCALE) return NEG_FULL_SCALE;
      return $urandom_range(1) ? (~m + 1'b1) : m;
   endfunction

   // ---------------- tests ----------------
   task automatic test_default_ballistics();
      send_sample(24'd0, 24'd0, 1'b1);
      send_sample(24'h400000, -24'sd256, 1'b0);
      send_sample(-24'sd5, 24'h123456, 1'b1);
      send_sample(24'h000010, 24'h000010, 1'b1);
      send_sample(24'h000010, -24'sd16, 1'b1);
      drain_meter();
   endtask

   task automatic test_register_extremes();
      write_reg(unused_index(), 24'hFFFFFF);
      write_reg(CSR_HOLD_BLOCKS, 24'hA50000);
      write_reg(CSR_PEAK_DECAY, 24'h008000);
      write_reg(CSR_LEVEL_DECAY, 24'h5AFFFF);
      write_reg(CSR_CLIP_THRESH, NEG_FULL_SCALE);
      send_sample(24'd1, 24'd1, 1'b1);
      send_sample(24'd1, 24'd1, 1'b1);
      send_sample(POS_FULL_SCALE, POS_FULL_SCALE, 1'b1);
      send_sample(NEG_FULL_SCALE, 24'h800001, 1'b0);
      send_sample(24'd3, POS_FULL_SCALE, 1'b1);
      drain_meter();
      write_reg(CSR_LEVEL_DECAY, 24'd0);
      write_reg(CSR_PEAK_DECAY, 24'd0);
      write_reg(CSR_HOLD_BLOCKS, 24'h00FFFF);
      write_reg(CSR_CLIP_THRESH, 24'd0);
      send_sample(24'd0, 24'd0, 1'b1);
      send_sample(24'd7, -24'sd9, 1'b1);
      send_sample(NEG_FULL_SCALE, NEG_FULL_SCALE, 1'b0);
      send_sample(24'd0, 24'd0, 1'b1);
      send_sample(24'd0, 24'd0, 1'b1);
      drain_meter();
   endtask

   task automatic test_random_traffic(input int snd_pct, input int rcv_pct, input int n_items);
      int  sent;
      int  len;
      bit  paused;
      sent = 0;
      paused = 1'b0;
      send_idle_pct   = snd_pct;
      ready_stall_pct = rcv_pct;
      randomize_registers();
      while (sent < n_items) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 4);
         for (int k = 0; k < len; k++)
            send_sample(pick_sample(left_chan), pick_sample(right_chan), k == len - 1);
         sent += len;
         if (!paused && sent >= n_items / 2) begin
            drain_meter();
            randomize_registers();
            paused = 1'b1;
         end
      end
      drain_meter();
   endtask

   initial begin
      meter_cfg.level_decay = LEVEL_DECAY_RST;
      meter_cfg.hold_blocks = HOLD_BLOCKS_RST;
      meter_cfg.peak_decay  = PEAK_DECAY_RST;
      meter_cfg.clip_thresh = CLIP_THRESH_RST;
      left_chan  = '0;
      right_chan = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_default_ballistics();
      test_register_extremes();
      test_random_traffic(20, 71, 310);
      test_random_traffic(71, 20, 310);
      test_random_traffic(0, 0, 310);

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && meter_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl
rtl/spmb_pkg.sv
rtl/spmb_lane.sv
rtl/spmb_merge.sv
rtl/stereo_peak_meter_ballistics_top.sv
rtl/spmb_checker.sv
tb/stereo_peak_meter_ballistics_top_tb.sv
